@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the neighbor table random walk unit.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ rtl/ntrw_pkg.sv @@
// Types and constants for the neighbor table random walk unit.
// Used by the front end, the back end and the top level.
package ntrw_pkg;
	localparam int CfgIdxBits = 2;
	localparam int CfgDataBits = 16;
	localparam logic [CfgIdxBits-1:0] CFG_OWN_ADDRESS = 2'd0;
	localparam logic [CfgIdxBits-1:0] CFG_START_HOP_COUNT = 2'd1;
	localparam logic [CfgIdxBits-1:0] CFG_STALE_SECONDS = 2'd2;

	localparam logic [1:0] ACT_BEACON = 2'd0;
	localparam logic [1:0] ACT_WALK = 2'd1;
	localparam logic [1:0] ACT_START = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam logic [2:0] KIND_RECORDED = 3'd0;
	localparam logic [2:0] KIND_FORWARD = 3'd1;
	localparam logic [2:0] KIND_REPLY = 3'd2;
	localparam logic [2:0] KIND_FINISHED = 3'd3;
	localparam logic [2:0] KIND_NONE = 3'd4;

	typedef struct packed {
		logic [1:0] action;
		logic [15:0] neighbor_address;
		logic [15:0] walk_origin;
		logic [7:0] hop_count;
		logic [31:0] now_seconds;
		logic [15:0] random_value;
	} in_item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [15:0] dest_address;
		logic [7:0] out_hop_count;
		logic [15:0] walk_source;
	} out_item_t;

	// Operation handed from the front end to the back end.
	typedef enum logic [1:0] {
		OP_BEACON = 2'd0,
		OP_SEND = 2'd1,
		OP_DIRECT = 2'd2
	} op_t;

	typedef struct packed {
		op_t op;
		logic [15:0] addr;
		logic [31:0] now;
		logic [15:0] rnd;
		logic [15:0] origin;
		logic [7:0] hops;
		out_item_t direct;
	} cmd_t;
endpackage

@@ rtl/ntrw_front.sv @@
// Front end: accepts items, classifies them and queues commands.
// Depends on ntrw_pkg.
module ntrw_front (
	input logic clk,
	input logic arst_n,
	input logic take,
	input ntrw_pkg::in_item_t item,
	input logic [15:0] own_address,
	input logic [7:0] start_hop_count,
	input logic pop,
	output logic full,
	output logic cmd_valid,
	output ntrw_pkg::cmd_t cmd
);
	import ntrw_pkg::*;

	cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t c;
	logic [7:0] left;

	always_comb begin
		left = (item.hop_count == 8'd0) ? 8'd0 : item.hop_count - 8'd1;
		c = '0;
		c.addr = item.neighbor_address;
		c.now = item.now_seconds;
		c.rnd = item.random_value;
		case (item.action)
			ACT_BEACON: c.op = OP_BEACON;
			ACT_WALK: begin
				if (left != 8'd0) begin
					c.op = OP_SEND;
					c.origin = item.walk_origin;
					c.hops = left;
				end else begin
					c.op = OP_DIRECT;
					if (item.walk_origin == own_address) begin
						c.direct.kind = KIND_FINISHED;
					end else begin
						c.direct.kind = KIND_REPLY;
						c.direct.dest_address = item.walk_origin;
					end
				end
			end
			default: begin
				c.op = OP_SEND;
				c.origin = own_address;
				c.hops = start_hop_count;
			end
		endcase
	end

	wire push = take && item.action != ACT_UNUSED;
	assign full = cnt_q == 2'd2;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

@@ rtl/ntrw_back.sv @@
// Back end: scans the neighbor table one slot a cycle and emits results.
// Depends on ntrw_pkg.
module ntrw_back #(
	parameter int TABLE_ENTRIES = 16,
	parameter int ADDRESS_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input ntrw_pkg::cmd_t cmd,
	input logic [15:0] stale_seconds,
	output logic pop,
	output logic done,
	output ntrw_pkg::out_item_t result
);
	import ntrw_pkg::*;

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int AW = (ADDRESS_BITS < 16) ? ADDRESS_BITS : 16;
	localparam logic [IW:0] LAST = (IW + 1)'(TABLE_ENTRIES - 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_AGE = 6'b000010,
		ST_SCAN = 6'b000100,
		ST_MOD = 6'b001000,
		ST_PICK = 6'b010000,
		ST_OUT = 6'b100000
	} state_t;

	state_t state_q;
	logic valid_q [TABLE_ENTRIES];
	logic [7:0] cnt_mem_q [TABLE_ENTRIES];
	logic [AW-1:0] addr_mem_q [TABLE_ENTRIES];
	logic [31:0] seen_mem_q [TABLE_ENTRIES];

	cmd_t cmd_q;
	logic [IW:0] idx_q;
	logic [7:0] lo_q, hi_q;
	logic [IW-1:0] slot_min_q, slot_save_q;
	logic have_save_q;
	logic [CW-1:0] count_q;
	logic [15:0] rem_q;
	logic [4:0] bit_q;
	out_item_t res_q;
	logic done_q;

	wire [IW-1:0] ix = idx_q[IW-1:0];
	wire [AW-1:0] my_addr = cmd_q.addr[AW-1:0];
	wire [31:0] age = cmd_q.now - seen_mem_q[ix];
	wire [16:0] rem_sh = {rem_q, cmd_q.rnd[bit_q[3:0]]};
	wire [16:0] cnt_ext = 17'(count_q);

	assign pop = state_q == ST_IDLE && cmd_valid;
	assign done = done_q;
	assign result = res_q;

	always_ff @(posedge clk) begin
		if (pop) cmd_q <= cmd;
		if (state_q == ST_SCAN && idx_q == LAST + 1'b1 && cmd_q.op == OP_BEACON) begin
			addr_mem_q[slot_save_q] <= my_addr;
			seen_mem_q[slot_save_q] <= cmd_q.now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
			for (int i = 0; i < TABLE_ENTRIES; i++) valid_q[i] <= 1'b0;
			for (int i = 0; i < TABLE_ENTRIES; i++) cnt_mem_q[i] <= 8'd0;
			idx_q <= '0;
			lo_q <= 8'hff;
			hi_q <= '0;
			slot_min_q <= '0;
			slot_save_q <= '0;
			have_save_q <= 1'b0;
			count_q <= '0;
			rem_q <= '0;
			bit_q <= '0;
			res_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					lo_q <= 8'hff;
					hi_q <= '0;
					slot_min_q <= '0;
					have_save_q <= 1'b0;
					count_q <= '0;
					rem_q <= '0;
					bit_q <= 5'd15;
					if (pop) begin
						case (cmd.op)
							OP_BEACON: state_q <= ST_AGE;
							OP_SEND: state_q <= ST_SCAN;
							default: begin
								res_q <= cmd.direct;
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_AGE: begin
					if (valid_q[ix] && age > {16'd0, stale_seconds}) valid_q[ix] <= 1'b0;
					if (idx_q == LAST) begin
						idx_q <= '0;
						state_q <= ST_SCAN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (idx_q == LAST + 1'b1) begin
						if (cmd_q.op == OP_BEACON) begin
							valid_q[slot_save_q] <= 1'b1;
							cnt_mem_q[slot_save_q] <= hi_q + 8'd1;
							res_q <= '0;
							res_q.kind <= KIND_RECORDED;
							state_q <= ST_OUT;
						end else if (count_q == '0) begin
							res_q <= '0;
							res_q.kind <= KIND_NONE;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_MOD;
						end
						idx_q <= '0;
					end else begin
						if (cmd_q.op == OP_BEACON) begin
							logic [7:0] c, lo_n;
							c = cnt_mem_q[ix];
							lo_n = (c < lo_q) ? c : lo_q;
							lo_q <= lo_n;
							if (c > hi_q) hi_q <= c;
							if (c == lo_n) slot_min_q <= ix;
							if (valid_q[ix] && addr_mem_q[ix] == my_addr) begin
								slot_save_q <= ix;
								have_save_q <= 1'b1;
							end else if (!have_save_q && !valid_q[ix]) begin
								slot_save_q <= ix;
								have_save_q <= 1'b1;
							end
							if (idx_q == LAST && !(have_save_q ||
								!valid_q[ix] || addr_mem_q[ix] == my_addr)) begin
								slot_save_q <= (c == lo_n) ? ix : slot_min_q;
							end
						end else if (valid_q[ix]) begin
							count_q <= count_q + 1'b1;
						end
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_MOD: begin
					// restoring remainder, one dividend bit per cycle
					if (rem_sh >= cnt_ext) rem_q <= 16'(rem_sh - cnt_ext);
					else rem_q <= rem_sh[15:0];
					if (bit_q == 5'd0) state_q <= ST_PICK;
					bit_q <= bit_q - 5'd1;
				end
				ST_PICK: begin
					if (valid_q[ix]) begin
						if (rem_q == 16'd0) begin
							res_q.kind <= KIND_FORWARD;
							res_q.dest_address <= 16'(addr_mem_q[ix]);
							res_q.out_hop_count <= cmd_q.hops;
							res_q.walk_source <= cmd_q.origin;
							state_q <= ST_OUT;
						end
						rem_q <= rem_q - 16'd1;
					end
					idx_q <= idx_q + 1'b1;
				end
				ST_OUT: begin
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/neighbor_table_random_walk_unit.sv @@
// Top level of the neighbor table random walk unit: config registers,
// front end queue and back end table engine. Depends on ntrw_pkg,
// ntrw_front, ntrw_back and assert_macros.svh.
//
// channel    ports                          handshake
// config     cfg_we, cfg_index, cfg_data     write when cfg_we high
// command    start, busy, item               taken when start && !busy
// result     result_strobe, result           valid one cycle, no stall
//
// A beacon runs an aging sweep and a slot scan; a walk to forward runs a count
// scan, a 16-bit remainder and a pick scan. The one-slot-per-cycle table scan in
// the back end sets the rate.
// A two-entry command queue lets the front take items while the back works;
// busy is high when that queue is full. Reset empties the table and the queue.
module neighbor_table_random_walk_unit #(
	parameter int TABLE_ENTRIES = 16,
	parameter int ADDRESS_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input ntrw_pkg::in_item_t item,
	input logic cfg_we,
	input logic [ntrw_pkg::CfgIdxBits-1:0] cfg_index,
	input logic [ntrw_pkg::CfgDataBits-1:0] cfg_data,
	output logic result_strobe,
	output ntrw_pkg::out_item_t result
);
	import ntrw_pkg::*;
	`include "assert_macros.svh"

	logic [15:0] own_address_q;
	logic [7:0] start_hop_count_q;
	logic [15:0] stale_seconds_q;
	logic full, cmd_valid, pop;
	cmd_t cmd;

	// Hold register values; the user must write them only while idle (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= 16'd0;
			start_hop_count_q <= 8'd5;
			stale_seconds_q <= 16'd60;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OWN_ADDRESS: own_address_q <= cfg_data;
				CFG_START_HOP_COUNT: start_hop_count_q <= cfg_data[7:0];
				CFG_STALE_SECONDS: stale_seconds_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = full;

	ntrw_front u_front (
		.clk(clk), .arst_n(arst_n), .take(start && !busy), .item(item),
		.own_address(own_address_q), .start_hop_count(start_hop_count_q),
		.pop(pop), .full(full), .cmd_valid(cmd_valid), .cmd(cmd)
	);

	ntrw_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .ADDRESS_BITS(ADDRESS_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd),
		.stale_seconds(stale_seconds_q), .pop(pop), .done(result_strobe),
		.result(result)
	);

	`ASSERT_IMPLIES(a_pop_needs_cmd, clk, arst_n, pop, cmd_valid, "pop from empty queue")
	`ASSERT_NEXT(a_strobe_single, clk, arst_n, result_strobe, !result_strobe, "strobe repeated")
	`ASSERT_IMPLIES(a_kind_legal, clk, arst_n, result_strobe, result.kind <= KIND_NONE, "bad kind")
endmodule
